/* hdl/prkc_pkg.sv */
// ----------------------------------------------------------------------------
// Rolling-key packet cipher package
// Shared widths, limits, status codes and the result record.
// ----------------------------------------------------------------------------
package prkc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MAX_PACKET = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY1_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2_SEED = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_OVERSIZE = 2'd2
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic               last;
    status_e            status;
    logic [BYTE_W-1:0]  key1;
    logic [BYTE_W-1:0]  key2;
  } result_t;

endpackage

/* hdl/prkc_if.sv */
// ----------------------------------------------------------------------------
// Rolling-key packet cipher channels
// Valid/ready channels for input packet bytes and for result items.
// ----------------------------------------------------------------------------
interface prkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       action;

  modport source (output valid, output in_byte, output action, input ready);
  modport sink   (input valid, input in_byte, input action, output ready);
endinterface

interface prkc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [11:0] out_index;
  logic        out_last;
  logic [1:0]  status;
  logic [7:0]  key1_now;
  logic [7:0]  key2_now;

  modport source (output valid, output out_byte, output out_index, output out_last,
                  output status, output key1_now, output key2_now, input ready);
  modport sink   (input valid, input out_byte, input out_index, input out_last,
                  input status, input key1_now, input key2_now, output ready);
endinterface

/* hdl/packet_rolling_key_cipher.sv */
// ----------------------------------------------------------------------------
// Rolling-key packet cipher
// Encodes or decodes a packet one byte per item with two chained running keys.
// ----------------------------------------------------------------------------
// A result is written into the result queue when its input item is accepted.
// Throughput: one item per cycle; the final byte of a long packet yields two
// results, which drain from a four-entry result queue one per cycle when taken.
// Input is taken while the queue has room for two results.
// Reset clears the running keys, the chain state and the queue; the block
// then awaits the first byte of a packet.
module packet_rolling_key_cipher
  import prkc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  prkc_in_if.sink              in_ch,
  prkc_out_if.source           out_ch
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] MaxSize = POS_W'(MAX_PACKET);

  logic [BYTE_W-1:0] k1_q, k1_d, k2_q, k2_d;
  logic [BYTE_W-1:0] cx_q, cx_d, cs_q, cs_d;
  logic [BYTE_W-1:0] low_q, low_d, chk_q, chk_d;
  logic [POS_W-1:0]  pos_q, pos_d, size_q, size_d;
  logic              dir_q, dir_d;

  result_t           fifo_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  logic              accept, pop;
  logic [1:0]        n_push;
  result_t           res0, res1;

  logic [BYTE_W-1:0] b, k1_new, k2_new, enc, dec, cx_new;
  logic [POS_W-1:0]  hdr_size, size_fix;
  logic              last;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (count_q <= CNT_W'(DEPTH - 2));
  assign b = in_ch.in_byte;

  always_comb begin
    hdr_size = {b, low_q};
    size_fix = (hdr_size < POS_W'(2)) ? POS_W'(2) : hdr_size;
    last     = ({1'b0, pos_q} + (POS_W+1)'(1)) >= {1'b0, size_q};
    k1_new   = (pos_q == '0) ? k1_q + 8'd1 : k1_q;
    k2_new   = (pos_q == '0) ? k2_q + 8'd1 : k2_q;
    cx_new   = cx_q ^ b;
    enc      = cx_new + cs_q;
    dec      = (b - cs_q) ^ cx_q;

    k1_d = k1_q; k2_d = k2_q; cx_d = cx_q; cs_d = cs_q;
    low_d = low_q; chk_d = chk_q; pos_d = pos_q; size_d = size_q; dir_d = dir_q;
    n_push = 2'd0;
    res0 = '{data: b, index: pos_q[INDEX_W-1:0], last: 1'b0, status: STATUS_OK,
             key1: k1_new, key2: k2_new};
    res1 = res0;

    if (accept) begin
      if (pos_q == '0) begin
        dir_d  = in_ch.action;
        k1_d   = k1_new;
        k2_d   = k2_new;
        low_d  = b;
        pos_d  = POS_W'(1);
        n_push = 2'd1;
      end else if (pos_q == POS_W'(1)) begin
        size_d = size_fix;
        cx_d   = k1_q;
        cs_d   = k2_q;
        chk_d  = k1_q;
        n_push = 2'd1;
        if (size_fix > MaxSize) begin
          res0.last   = 1'b1;
          res0.status = STATUS_OVERSIZE;
          pos_d       = POS_W'(2);
        end else begin
          res0.last = (size_fix == POS_W'(2));
          pos_d     = res0.last ? '0 : POS_W'(2);
        end
      end else begin
        pos_d = last ? '0 : pos_q + POS_W'(1);
        if (size_q > MaxSize) begin
          n_push = 2'd0;
        end else if (size_q <= POS_W'(3)) begin
          res0.last = last;
          n_push    = 2'd1;
        end else if (pos_q == POS_W'(2)) begin
          if (dir_q) begin
            chk_d = b - chk_q;
          end
        end else if (!dir_q) begin
          cx_d      = cx_new;
          cs_d      = cs_q + b;
          res0.data = enc;
          res1.data = b + chk_q;
          n_push    = last ? 2'd2 : 2'd1;
        end else begin
          cx_d      = cx_q ^ dec;
          cs_d      = cs_q + dec;
          res0.data = dec;
          res1.data = chk_q;
          res1.status = (chk_q == dec) ? STATUS_OK : STATUS_MISMATCH;
          n_push    = last ? 2'd2 : 2'd1;
        end
        res1.index = INDEX_W'(2);
        res1.last  = 1'b1;
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY1_SEED: k1_d = cfg_data_i;
        CFG_KEY2_SEED: k2_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0; k2_q <= '0; cx_q <= '0; cs_q <= '0;
      low_q <= '0; chk_q <= '0; pos_q <= '0; size_q <= '0; dir_q <= 1'b0;
      wr_ptr_q <= '0; rd_ptr_q <= '0; count_q <= '0;
    end else begin
      k1_q <= k1_d; k2_q <= k2_d; cx_q <= cx_d; cs_q <= cs_d;
      low_q <= low_d; chk_q <= chk_d; pos_q <= pos_d; size_q <= size_d; dir_q <= dir_d;
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
    end
  end

  assign out_ch.valid     = (count_q != '0);
  assign out_ch.out_byte  = fifo_q[rd_ptr_q].data;
  assign out_ch.out_index = fifo_q[rd_ptr_q].index;
  assign out_ch.out_last  = fifo_q[rd_ptr_q].last;
  assign out_ch.status    = fifo_q[rd_ptr_q].status;
  assign out_ch.key1_now  = fifo_q[rd_ptr_q].key1;
  assign out_ch.key2_now  = fifo_q[rd_ptr_q].key2;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_pair_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd2) |-> (res1.last && !res0.last && res1.index == INDEX_W'(2)))
    else $error("second result of an item does not close the packet");

  a_error_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0 && res0.status != STATUS_OK) |-> res0.last)
    else $error("error status on a result that is not last");

  a_start_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pos_q == '0) |=> (pos_q == POS_W'(1)))
    else $error("packet start did not advance the byte position");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rolling-key packet cipher testbench
// Sends packets of bytes in both directions: short, tiny, oversize and
// properly sealed or tampered decode packets. Seed writes are made between
// phases and once in the middle of a packet. Both sides idle at random. A
// local copy of the cipher predicts every result, and each returned result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import prkc_pkg::*;

  localparam logic        ACT_ENCODE    = 1'b0;
  localparam logic        ACT_DECODE    = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 50;

  typedef enum int unsigned {PKT_RAW, PKT_SEALED, PKT_TAMPERED} pkt_form_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              action;
  } pkt_byte_t;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [BYTE_W-1:0]    cfg_data  = '0;
  logic                 tx_valid  = 1'b0;
  logic [BYTE_W-1:0]    tx_byte   = '0;
  logic                 tx_action = 1'b0;
  logic                 rx_ready  = 1'b0;

  prkc_in_if  in_ch();
  prkc_out_if out_ch();

  assign in_ch.valid  = tx_valid;
  assign in_ch.in_byte = tx_byte;
  assign in_ch.action = tx_action;
  assign out_ch.ready = rx_ready;

  packet_rolling_key_cipher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Predicted cipher state.
  logic [BYTE_W-1:0] cur_key1   = '0;
  logic [BYTE_W-1:0] cur_key2   = '0;
  logic [BYTE_W-1:0] xor_chain  = '0;
  logic [BYTE_W-1:0] sum_chain  = '0;
  logic [POS_W-1:0]  pkt_pos    = '0;
  logic [POS_W-1:0]  pkt_len    = '0;
  logic [BYTE_W-1:0] len_low    = '0;
  logic [BYTE_W-1:0] check_byte = '0;
  logic              decoding   = 1'b0;

  // Keys that the stimulus expects at the next packet start.
  logic [BYTE_W-1:0] plan_key1 = '0;
  logic [BYTE_W-1:0] plan_key2 = '0;

  pkt_byte_t byte_queue[$];
  pkt_byte_t staged[$];
  result_t   pending_out[$];
  pkt_byte_t tx_next;

  int unsigned gap_left    = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_cycle    = 0;
  int unsigned live_items  = 0;
  int unsigned n_items     = 0;
  int unsigned n_packets   = 0;
  int unsigned n_results   = 0;
  int unsigned n_bad_check = 0;
  int unsigned n_oversize  = 0;
  int unsigned errors      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(30_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic void add_result(input logic [BYTE_W-1:0] data, input logic [POS_W-1:0] pos,
                                     input logic lst, input status_e st);
    result_t r;
    r.data   = data;
    r.index  = pos[INDEX_W-1:0];
    r.last   = lst;
    r.status = st;
    r.key1   = cur_key1;
    r.key2   = cur_key2;
    pending_out.push_back(r);
  endfunction

  function automatic void cipher_step(input logic [BYTE_W-1:0] data, input logic act);
    logic [POS_W:0]    next_pos;
    logic [POS_W-1:0]  size;
    logic [POS_W-1:0]  cur_pos;
    logic              lst;
    logic [BYTE_W-1:0] plain;
    if (pkt_pos == 0) begin
      decoding = (act == ACT_DECODE);
      cur_key1++;
      cur_key2++;
      len_low = data;
      add_result(data, 16'd0, 1'b0, STATUS_OK);
      pkt_pos = 16'd1;
    end else if (pkt_pos == 1) begin
      size = {data, len_low};
      if (size < 16'd2) begin
        size = 16'd2;
      end
      pkt_len    = size;
      xor_chain  = cur_key1;
      sum_chain  = cur_key2;
      check_byte = cur_key1;
      if (size > MAX_PACKET) begin
        add_result(data, 16'd1, 1'b1, STATUS_OVERSIZE);
        pkt_pos = 16'd2;
      end else begin
        lst = (size == 16'd2);
        add_result(data, 16'd1, lst, STATUS_OK);
        pkt_pos = lst ? 16'd0 : 16'd2;
      end
    end else begin
      cur_pos  = pkt_pos;
      next_pos = {1'b0, pkt_pos} + 17'd1;
      lst      = (next_pos >= {1'b0, pkt_len});
      pkt_pos  = lst ? 16'd0 : next_pos[POS_W-1:0];
      if (pkt_len <= MAX_PACKET) begin
        if (pkt_len <= 16'd3) begin
          add_result(data, cur_pos, lst, STATUS_OK);
        end else if (cur_pos == 16'd2) begin
          if (decoding) begin
            check_byte = 8'(data - check_byte);
          end
        end else if (!decoding) begin
          xor_chain = xor_chain ^ data;
          add_result(8'(xor_chain + sum_chain), cur_pos, 1'b0, STATUS_OK);
          sum_chain = 8'(sum_chain + data);
          if (lst) begin
            add_result(8'(data + check_byte), 16'd2, 1'b1, STATUS_OK);
          end
        end else begin
          plain     = 8'(data - sum_chain) ^ xor_chain;
          xor_chain = xor_chain ^ plain;
          sum_chain = 8'(sum_chain + plain);
          add_result(plain, cur_pos, 1'b0, STATUS_OK);
          if (lst) begin
            add_result(check_byte, 16'd2, 1'b1,
                       (check_byte == plain) ? STATUS_OK : STATUS_MISMATCH);
          end
        end
      end
    end
  endfunction

  function automatic void stage_byte(input logic [BYTE_W-1:0] data, input logic act);
    pkt_byte_t b;
    b.data   = data;
    b.action = act;
    staged.push_back(b);
  endfunction

  // A sealed packet is the encoding of a random message under the keys that
  // the block will use, so that decoding it must succeed.
  function automatic void build_packet(input logic [POS_W-1:0] size, input logic act,
                                       input pkt_form_e form);
    int unsigned       n;
    int unsigned       i;
    int unsigned       at;
    logic [BYTE_W-1:0] plain[];
    logic [BYTE_W-1:0] xr;
    logic [BYTE_W-1:0] sm;
    n = (size < 2) ? 2 : size;
    plan_key1++;
    plan_key2++;
    n_packets++;
    live_items += (size > MAX_PACKET) ? 2 : n;
    stage_byte(size[7:0], act);
    stage_byte(size[15:8], 1'($urandom));
    if (form == PKT_RAW || n <= 3 || size > MAX_PACKET) begin
      for (i = 2; i < n; i++) begin
        stage_byte(8'($urandom), 1'($urandom));
      end
    end else begin
      plain = new[n];
      for (i = 3; i < n; i++) begin
        plain[i] = 8'($urandom);
      end
      xr = plan_key1;
      sm = plan_key2;
      stage_byte(8'(plain[n-1] + plan_key1), 1'($urandom));
      for (i = 3; i < n; i++) begin
        xr = xr ^ plain[i];
        stage_byte(8'(xr + sm), 1'($urandom));
        sm = 8'(sm + plain[i]);
      end
      if (form == PKT_TAMPERED) begin
        at = staged.size() - n + $urandom_range(2, n - 1);
        staged[at].data = staged[at].data ^ 8'($urandom_range(1, 255));
      end
    end
  endfunction

  task automatic release_staged(input int unsigned count);
    @(negedge clk_i);
    repeat (count) begin
      byte_queue.push_back(staged.pop_front());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (byte_queue.size() != 0 || tx_valid || pending_out.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY1_SEED) begin
      cur_key1  = value;
      plan_key1 = value;
    end else begin
      cur_key2  = value;
      plan_key2 = value;
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned      goal;
    int unsigned      r;
    logic [POS_W-1:0] size;
    logic             act;
    pkt_form_e        form;
    goal = live_items + quota;
    while (live_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        size = POS_W'($urandom_range(0, 3));
      end else if (r < 85) begin
        size = POS_W'($urandom_range(4, 24));
      end else if (r < 96) begin
        size = POS_W'($urandom_range(25, 80));
      end else begin
        size = POS_W'($urandom_range(256, 300));
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        act  = ACT_ENCODE;
        form = PKT_RAW;
      end else if (r < 80) begin
        act  = ACT_DECODE;
        form = PKT_SEALED;
      end else if (r < 90) begin
        act  = ACT_DECODE;
        form = PKT_TAMPERED;
      end else begin
        act  = ACT_DECODE;
        form = PKT_RAW;
      end
      build_packet(size, act, form);
    end
    release_staged(staged.size());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && tx_valid && in_ch.ready) begin
      cipher_step(tx_byte, tx_action);
      n_items++;
    end
    if (!rst_ni) begin
      tx_valid <= 1'b0;
    end else if (!tx_valid || in_ch.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        tx_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        tx_next = byte_queue.pop_front();
        tx_valid  <= 1'b1;
        tx_byte   <= tx_next.data;
        tx_action <= tx_next.action;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  task automatic check_result();
    result_t want;
    n_results++;
    if (pending_out.size() == 0) begin
      report_mismatch($sformatf("unexpected result: byte %02h at index %0d",
                                out_ch.out_byte, out_ch.out_index));
    end else begin
      want = pending_out.pop_front();
      if (want.last && want.status == STATUS_MISMATCH) n_bad_check++;
      if (want.last && want.status == STATUS_OVERSIZE) n_oversize++;
      if (out_ch.out_byte !== want.data)
        report_mismatch($sformatf("index %0d: byte %02h, expected %02h",
                                  want.index, out_ch.out_byte, want.data));
      if (out_ch.out_index !== want.index)
        report_mismatch($sformatf("index %0d, expected %0d", out_ch.out_index, want.index));
      if (out_ch.out_last !== want.last)
        report_mismatch($sformatf("index %0d: last %b, expected %b",
                                  want.index, out_ch.out_last, want.last));
      if (out_ch.status !== want.status)
        report_mismatch($sformatf("index %0d: status %0d, expected %0d",
                                  want.index, out_ch.status, want.status));
      if (out_ch.key1_now !== want.key1)
        report_mismatch($sformatf("index %0d: key1 %02h, expected %02h",
                                  want.index, out_ch.key1_now, want.key1));
      if (out_ch.key2_now !== want.key2)
        report_mismatch($sformatf("index %0d: key2 %02h, expected %02h",
                                  want.index, out_ch.key2_now, want.key2));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && rx_ready) begin
      check_result();
    end
    rx_cycle++;
    case (rx_cycle[9:8])
      2'd0: rx_ready <= 1'b1;
      2'd1: rx_ready <= ($urandom_range(0, 3) != 0);
      2'd2: rx_ready <= ((rx_cycle % 5) < 2);
      default: rx_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    build_packet(16'd0, ACT_ENCODE, PKT_RAW);
    build_packet(16'd1, ACT_DECODE, PKT_RAW);
    build_packet(16'd2, ACT_DECODE, PKT_RAW);
    build_packet(16'd3, ACT_ENCODE, PKT_RAW);
    build_packet(16'd3, ACT_DECODE, PKT_RAW);
    build_packet(16'd4, ACT_ENCODE, PKT_RAW);
    build_packet(16'd4, ACT_DECODE, PKT_SEALED);
    build_packet(16'd6, ACT_DECODE, PKT_TAMPERED);
    release_staged(staged.size());
    wait_idle();

    write_seed(CFG_KEY1_SEED, 8'hFF);
    write_seed(CFG_KEY2_SEED, 8'hFF);
    random_phase(350);
    wait_idle();

    write_seed(CFG_KEY1_SEED, 8'h00);
    write_seed(CFG_KEY2_SEED, 8'h80);
    random_phase(350);
    wait_idle();

    write_seed(CFG_KEY1_SEED, 8'h7F);
    write_seed(CFG_KEY2_SEED, 8'h00);
    random_phase(350);
    wait_idle();

    // The seeds change while a sealed packet is half sent.
    build_packet(16'd12, ACT_DECODE, PKT_SEALED);
    release_staged(6);
    wait_idle();
    write_seed(CFG_KEY2_SEED, 8'($urandom));
    write_seed(CFG_KEY1_SEED, 8'($urandom));
    release_staged(staged.size());
    random_phase(350);
    wait_idle();

    write_seed(CFG_KEY1_SEED, 8'($urandom));
    write_seed(CFG_KEY2_SEED, 8'($urandom));
    random_phase(350);
    wait_idle();

    write_seed(CFG_KEY2_SEED, 8'h01);
    random_phase(300);
    wait_idle();

    // An oversize packet closes the run; only its first few bytes are sent.
    build_packet(16'd4097, ACT_DECODE, PKT_RAW);
    release_staged(12);
    wait_idle();

    $display("Run covered %0d bytes in %0d packets and checked %0d results.",
             n_items, n_packets, n_results);
    $display("Decode check failures expected: %0d, oversize packets: %0d, mismatches: %0d.",
             n_bad_check, n_oversize, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/prkc_pkg.sv
hdl/prkc_if.sv
hdl/packet_rolling_key_cipher.sv
tb/sv/tb.sv
